>>> src/muxed_seven_segment_shift_driver_assert.svh
// assertion macros shared by the checker files of the display driver
// depends on nothing; the including module must provide clk_i and rst_ni
`ifndef MUXED_SEVEN_SEGMENT_SHIFT_DRIVER_ASSERT_SVH
`define MUXED_SEVEN_SEGMENT_SHIFT_DRIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("display driver check failed");

// next-cycle implication, checked out of reset
`define MSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("display driver check failed");

`endif

>>> src/msd_pkg.sv
// shared types, constants and the segment decoder of the display driver
// no dependencies
package msd_pkg;

  // request kinds carried on the input tuser bit
  typedef enum logic {
    MSD_REQ_LOAD = 1'b0,
    MSD_REQ_TICK = 1'b1
  } msd_req_e;

  localparam int unsigned DigitW  = 4;
  localparam int unsigned SegW    = 7;
  localparam int unsigned RoundsW = 9;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned TickW   = 17;
  localparam int unsigned QuotW   = 7;

  // decoded item held between the input stage and the scan core
  typedef struct packed {
    msd_req_e               req_type;
    logic [DigitW-1:0]      ones;
    logic [QuotW-1:0]       quot;     // value divided by ten
    logic [RoundsW-1:0]     rounds;
  } msd_item_t;

  // segment pattern of one digit, blank above nine
  function automatic logic [SegW-1:0] msd_pattern(input logic [DigitW-1:0] d);
    logic [SegW-1:0] p;
    case (d)
      4'd0: p = 7'h3F;
      4'd1: p = 7'h06;
      4'd2: p = 7'h5B;
      4'd3: p = 7'h4F;
      4'd4: p = 7'h66;
      4'd5: p = 7'h6D;
      4'd6: p = 7'h7D;
      4'd7: p = 7'h07;
      4'd8: p = 7'h7F;
      4'd9: p = 7'h67;
      default: p = 7'h00;
    endcase
    return p;
  endfunction

endpackage

>>> src/msd_in_stage.sv
// input register of the display driver: takes an item and splits off the ones digit
// depends on msd_pkg
module msd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // value[9:0], rounds[18:10], zero fill
  input  logic                s_axis_tuser,   // req_type
  input  logic                take_i,
  output logic                valid_o,
  output msd_pkg::msd_item_t  item_o
);
  import msd_pkg::*;

  logic        valid_q, valid_d;
  msd_item_t   item_q, item_d;
  logic        accept;
  logic [9:0]  value;
  logic [17:0] prod;
  logic [6:0]  quot;
  logic [9:0]  rem;

  assign value = s_axis_tdata[9:0];

  // divide by ten as multiply by 205/2048, exact for ten-bit values
  assign prod = 18'(value) * 18'd205;
  assign quot = prod[17:11];
  assign rem  = value - {quot, 3'b000} - {2'b00, quot, 1'b0};

  assign s_axis_tready = !valid_q || take_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_d.req_type = msd_req_e'(s_axis_tuser);
    item_d.ones     = rem[DigitW-1:0];
    item_d.quot     = quot;
    item_d.rounds   = s_axis_tdata[18:10];
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

>>> src/msd_scan_core.sv
// scan state, pin step logic and result register of the display driver
// depends on msd_pkg
module msd_scan_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                valid_i,
  input  msd_pkg::msd_item_t  item_i,
  output logic                take_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata
);
  import msd_pkg::*;

  localparam logic [TickW-1:0] ShiftEnd = 17'd16;

  logic [HoldW-1:0]   hold_q;
  logic [DigitW-1:0]  digit_q [3];
  logic [DigitW-1:0]  digit_d [3];
  logic [RoundsW-1:0] rounds_q, rounds_d;
  logic [1:0]         slot_q, slot_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [2:0]         enable_q, enable_d;
  logic               latch_q, latch_d;
  logic               out_valid_q;
  logic [15:0]        out_data_q, out_data_d;

  logic               ser, sclk;
  logic [SegW-1:0]    segs, pat;
  logic [7:0]         pat_ext;
  logic [1:0]         slot;
  logic [TickW-1:0]   hold_end;
  logic [14:0]        prod;
  logic [3:0]         hund;
  logic [6:0]         tens;
  logic [2:0]         bit_sel;

  assign take_o = valid_i && (!out_valid_q || m_axis_tready);

  // tens and hundreds from the stored quotient
  assign prod = 15'(item_i.quot) * 15'd205;
  assign hund = prod[14:11];
  assign tens = item_i.quot - {hund, 3'b000} - {2'b00, hund, 1'b0};

  assign slot     = (slot_q == 2'd3) ? 2'd0 : slot_q;
  assign pat      = msd_pattern(digit_q[slot]);
  // eight shifted bits, the top one always low
  assign pat_ext  = {1'b0, pat};
  assign hold_end = ShiftEnd + ((hold_q == '0) ? 17'd1 : 17'(hold_q));
  assign bit_sel  = tick_q[3:1];

  // next scan state and pin values
  always_comb begin
    digit_d  = digit_q;
    rounds_d = rounds_q;
    slot_d   = slot_q;
    tick_d   = tick_q;
    enable_d = enable_q;
    latch_d  = latch_q;
    ser      = 1'b0;
    sclk     = 1'b0;
    segs     = '0;
    if (item_i.req_type == MSD_REQ_LOAD) begin
      digit_d[0] = item_i.ones;
      digit_d[1] = tens[DigitW-1:0];
      digit_d[2] = hund;
      rounds_d   = item_i.rounds;
      slot_d     = 2'd0;
      tick_d     = '0;
      if (item_i.rounds != '0) begin
        segs = msd_pattern(item_i.ones);
      end
    end else if (rounds_q != '0) begin
      segs = pat;
      if (tick_q < ShiftEnd) begin
        enable_d = 3'b111;
        latch_d  = 1'b0;
        ser      = pat_ext[bit_sel];
        sclk     = tick_q[0];
        tick_d   = tick_q + 17'd1;
      end else if (tick_q == ShiftEnd) begin
        latch_d = 1'b1;
        tick_d  = tick_q + 17'd1;
      end else begin
        enable_d = ~(3'b001 << slot);
        if (tick_q >= hold_end) begin
          tick_d = '0;
          if (slot == 2'd2) begin
            slot_d   = 2'd0;
            rounds_d = rounds_q - 9'd1;
          end else begin
            slot_d = slot + 2'd1;
          end
        end else begin
          tick_d = tick_q + 17'd1;
        end
      end
    end
    out_data_d = {2'b00, (rounds_d != '0), segs, enable_d, latch_d, sclk, ser};
  end

  // configuration and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 16'd3;
      digit_q[0]  <= '0;
      digit_q[1]  <= '0;
      digit_q[2]  <= '0;
      rounds_q    <= '0;
      slot_q      <= '0;
      tick_q      <= '0;
      enable_q    <= 3'b111;
      latch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hold_q <= cfg_wdata_i;
      end
      if (take_o) begin
        digit_q  <= digit_d;
        rounds_q <= rounds_d;
        slot_q   <= slot_d;
        tick_q   <= tick_d;
        enable_q <= enable_d;
        latch_q  <= latch_d;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
endmodule

>>> src/muxed_seven_segment_shift_driver.sv
// top level of the three-digit multiplexed seven-segment shift register driver
// depends on msd_pkg, msd_in_stage and msd_scan_core
//
// usage:
//   the input stream carries one item per handshake: tuser low loads a number
//   (tdata value and rounds), tuser high is one time tick. every item gives
//   exactly one result item on the output stream with the pin levels for the
//   serial data, shift clock, latch clock, the active-low digit enables, the
//   segment pattern being served and a busy flag.
//   cfg_we_i writes hold_ticks (ticks a digit stays lit after latching); write
//   it only while no item is in flight.
// timing:
//   an item accepted into the input register moves on to the result register
//   when the scan core takes it, with the scan state updated as the item moves
//   between them; one item is taken every cycle while the output side is not
//   stalled, set by the input register and result register pair.
// reset:
//   digits zero, no rounds left, all digits off, latch clock low, hold_ticks 3.
// stall:
//   a held result keeps its value; the input register still takes one more item,
//   then tready drops until the output side is taken.
module muxed_seven_segment_shift_driver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // hold_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // value[9:0], rounds[18:10], zero fill
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // ser_pin[0], shift_clk[1], latch_clk[2],
                                      // digit_off[5:3], segments[12:6],
                                      // busy_res[13], zero fill
);
  import msd_pkg::*;

  logic      in_valid;
  logic      take;
  msd_item_t in_item;

  // input register
  msd_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .take_i        (take),
    .valid_o       (in_valid),
    .item_o        (in_item)
  );

  // scan logic and result register
  msd_scan_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_i       (in_valid),
    .item_i        (in_item),
    .take_o        (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );
endmodule

>>> src/msd_port_checker.sv
// port-level checks of the display driver, bound to the top level
// depends on muxed_seven_segment_shift_driver_assert.svh
`include "muxed_seven_segment_shift_driver_assert.svh"

module msd_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  // a stalled result item holds
  `MSD_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // shifting only with latch low and all digits blanked
  `MSD_ASSERT_IMP(a_shift_blank, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[2] && m_axis_tdata[5:3] == 3'b111)
  // serial data or shift clock only during a scan
  `MSD_ASSERT_IMP(a_pins_busy, m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1]), m_axis_tdata[13])
  // at most one digit lit
  `MSD_ASSERT_IMP(a_one_digit, m_axis_tvalid, $countones(m_axis_tdata[5:3]) >= 2)
endmodule

bind muxed_seven_segment_shift_driver msd_port_checker u_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/muxed_seven_segment_shift_driver_tb.sv
// self-checking testbench for the multiplexed seven-segment shift register driver
// depends on msd_pkg and muxed_seven_segment_shift_driver; predicts every pin step
// from its own copy of the scan state and compares each output item field by field
`timescale 1ns / 100ps

module muxed_seven_segment_shift_driver_tb;
  import msd_pkg::*;

  // segment patterns for digits nine down to zero, zero in the lowest bits
  localparam logic [69:0] SegRom = {7'h67, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                    7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};
  localparam int unsigned IdlePct = 28;

  // one pin step as packed in m_axis_tdata[13:0]
  typedef struct packed {
    logic       busy;
    logic [6:0] segments;
    logic [2:0] digit_off;
    logic       latch_clk;
    logic       shift_clk;
    logic       ser_pin;
  } pin_step_t;

  // scan state copy, expected pin steps and the comparison
  class display_pin_board;
    logic [3:0]  digits [3];
    logic [8:0]  rounds_left;
    logic [1:0]  slot_index;
    logic [16:0] slot_tick;
    logic [2:0]  enable_n;
    logic        latch;
    logic [15:0] hold_ticks;
    pin_step_t   expected_pins [$];
    int unsigned faults;

    function new();
      digits[0] = 4'd0;
      digits[1] = 4'd0;
      digits[2] = 4'd0;
      rounds_left = '0;
      slot_index = '0;
      slot_tick = '0;
      enable_n = 3'b111;
      latch = 1'b0;
      hold_ticks = 16'd3;
      faults = 0;
    endfunction

    function void set_hold(logic [15:0] h);
      hold_ticks = h;
    endfunction

    function logic [6:0] pattern(logic [3:0] d);
      if (d < 4'd10) begin
        return SegRom[int'(d) * 7 +: 7];
      end
      return 7'd0;
    endfunction

    // advance the scan by one accepted item and queue the pin step it gives
    function void note_item(msd_req_e req, logic [9:0] val, logic [8:0] rnd);
      pin_step_t   p;
      int unsigned slot;
      int unsigned t;
      int unsigned hold;
      logic [7:0]  pat;
      p = '0;
      if (req == MSD_REQ_LOAD) begin
        digits[0] = 4'(val % 10);
        digits[1] = 4'((val / 10) % 10);
        digits[2] = 4'(val / 100);
        rounds_left = rnd;
        slot_index = '0;
        slot_tick = '0;
        if (rnd != 0) begin
          p.segments = pattern(digits[0]);
        end
      end else if (rounds_left != 0) begin
        slot = (slot_index < 3) ? slot_index : 0;
        pat = {1'b0, pattern(digits[slot])};
        hold = (hold_ticks == 0) ? 1 : hold_ticks;
        t = slot_tick;
        p.segments = pat[6:0];
        if (t < 16) begin
          // shift phase: digits blanked, pattern out lsb first
          enable_n = 3'b111;
          latch = 1'b0;
          p.ser_pin = pat[t >> 1];
          p.shift_clk = (t % 2) == 1;
          slot_tick = 17'(t + 1);
        end else if (t == 16) begin
          latch = 1'b1;
          slot_tick = 17'(t + 1);
        end else begin
          // hold phase: this slot's digit lit
          enable_n = ~(3'b001 << slot);
          if (t >= 16 + hold) begin
            slot_tick = '0;
            if (slot >= 2) begin
              slot_index = '0;
              rounds_left = rounds_left - 9'd1;
            end else begin
              slot_index = 2'(slot + 1);
            end
          end else begin
            slot_tick = 17'(t + 1);
          end
        end
      end
      p.latch_clk = latch;
      p.digit_off = enable_n;
      p.busy = (rounds_left != 0);
      expected_pins.push_back(p);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        faults++;
      end
    endfunction

    function void check_pins(logic [15:0] data);
      pin_step_t got;
      pin_step_t want;
      got = data[13:0];
      if (expected_pins.size() == 0) begin
        $display("%0t: unexpected item expected none actual %h", $time, data);
        faults++;
        return;
      end
      want = expected_pins.pop_front();
      report("ser_pin", want.ser_pin, got.ser_pin);
      report("shift_clk", want.shift_clk, got.shift_clk);
      report("latch_clk", want.latch_clk, got.latch_clk);
      report("digit_off", want.digit_off, got.digit_off);
      report("segments", want.segments, got.segments);
      report("busy_res", want.busy, got.busy);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;    // value[9:0], rounds[18:10], zero fill
  logic        s_axis_tuser;    // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // ser_pin, shift_clk, latch_clk, digit_off,
                                // segments, busy_res, zero fill
  logic        calm;            // no idling on either side while set

  display_pin_board board;

  muxed_seven_segment_shift_driver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      board.check_pins(m_axis_tdata);
    end
    m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
  end

  // one item on the input stream, with random idle cycles ahead of it
  task automatic send_item(msd_req_e req, logic [9:0] val, logic [8:0] rnd);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {5'd0, rnd, val};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(req, val, rnd);
  endtask

  // ticks carry random, ignored content in tdata
  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(MSD_REQ_TICK, 10'($urandom_range(1023)), 9'($urandom_range(511)));
  endtask

  // write hold_ticks once every expected item is back and the block is quiet
  task automatic write_hold(logic [15:0] h);
    s_axis_tvalid <= 1'b0;
    while (board.expected_pins.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_hold(h);
  endtask

  // mostly complete scans with random numbers, some cut short by the next load
  task automatic run_scans(int unsigned n);
    int unsigned done;
    int unsigned pick;
    int unsigned val;
    int unsigned rnd;
    int unsigned heff;
    int unsigned ticks;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      val = ($urandom_range(99) < 85) ? $urandom_range(999) : $urandom_range(1023, 1000);
      if (pick < 70) begin
        rnd = $urandom_range(2, 1);
      end else if (pick < 80) begin
        rnd = 0;
      end else begin
        rnd = $urandom_range(511, 3);
      end
      heff = (board.hold_ticks == 0) ? 1 : board.hold_ticks;
      if ($urandom_range(99) < 75) begin
        ticks = rnd * 3 * (17 + heff) + $urandom_range(6);
      end else begin
        ticks = $urandom_range(40, 1);
      end
      if (ticks > 160) begin
        ticks = 160;
      end
      send_item(MSD_REQ_LOAD, 10'(val), 9'(rnd));
      send_ticks(ticks);
      done += 1 + ticks;
    end
  endtask

  // main sequence
  initial begin
    board = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= MSD_REQ_LOAD;
    m_axis_tready <= 1'b0;
    calm <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle tick, zero rounds, number above range with the widest rounds,
    // run through shift, latch and first hold tick, then reload while lit
    send_ticks(1);
    send_item(MSD_REQ_LOAD, 10'd0, 9'd0);
    send_ticks(1);
    send_item(MSD_REQ_LOAD, 10'd1023, 9'd511);
    send_ticks(18);
    send_item(MSD_REQ_LOAD, 10'd999, 9'd1);
    send_ticks(1);
    run_scans(115);

    write_hold(16'd1);
    run_scans(115);
    // zero hold behaves as one hold tick
    write_hold(16'd0);
    run_scans(110);
    write_hold(16'd2);
    calm <= 1'b1;
    run_scans(115);
    write_hold(16'd65535);
    calm <= 1'b0;
    run_scans(90);
    write_hold(16'd5);
    run_scans(115);

    s_axis_tvalid <= 1'b0;
    while (board.expected_pins.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/msd_pkg.sv
src/msd_in_stage.sv
src/msd_scan_core.sv
src/muxed_seven_segment_shift_driver.sv
src/msd_port_checker.sv
tb/muxed_seven_segment_shift_driver_tb.sv
